/* design/sorted_delta_shift_queue_defines.svh */
// assertion macros shared by the checker of the sorted delta shift queue
// depends on nothing; included by the checker file only
`ifndef SORTED_DELTA_SHIFT_QUEUE_DEFINES_SVH
`define SORTED_DELTA_SHIFT_QUEUE_DEFINES_SVH

// same-cycle implication, disabled while reset is high
`define SDSQ_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sdsq check failed: same-cycle rule");

// next-cycle implication, disabled while reset is high
`define SDSQ_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sdsq check failed: next-cycle rule");

`endif

/* design/sdsq_pkg.sv */
// shared types and constants of the sorted delta shift queue
// no dependencies; imported by the controller, datapath and top level
package sdsq_pkg;

   localparam int QUEUE_DEPTH_DEF = 16;
   localparam int VALUE_W         = 32;
   localparam int ENTRY_COUNT_W   = 5;

   localparam logic [VALUE_W-1:0] Q_MAX = {1'b0, {(VALUE_W-1){1'b1}}};

   // request opcodes
   localparam logic CMD_PUSH = 1'b0;
   localparam logic CMD_POP  = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SQUEEZE,
      ST_DONE
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;     // perform the accepted push or pop
      logic squeeze;  // drop a zero entry at the head
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic empty;
      logic head_zero;
   } dp_status_type;

endpackage

/* design/sdsq_ctrl.sv */
// controller of the sorted delta shift queue: sequences load, squeeze and response
// depends on sdsq_pkg
module sdsq_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic                      req_cmd,
   input  sdsq_pkg::dp_status_type   status,
   output sdsq_pkg::dp_cmd_type      cmd,
   output logic                      busy,
   output logic                      rsp_valid
);
   import sdsq_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      busy        = 1'b1;
      rsp_valid   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               if (req_cmd == CMD_POP && !status.empty) begin
                  state_in = ST_SQUEEZE;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_SQUEEZE: begin
            // duplicates of the minimum became zero at the head
            if (!status.empty && status.head_zero) begin
               cmd.squeeze = 1'b1;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            rsp_valid = 1'b1;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

/* design/sdsq_datapath.sv */
// datapath of the sorted delta shift queue: entry cells, count and result registers
// depends on sdsq_pkg
module sdsq_datapath #(
   parameter int QUEUE_DEPTH = sdsq_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  sdsq_pkg::dp_cmd_type                      cmd,
   input  logic                                      req_cmd,
   input  logic signed [sdsq_pkg::VALUE_W-1:0]       req_value,
   output sdsq_pkg::dp_status_type                   status,
   output logic signed [sdsq_pkg::VALUE_W-1:0]       rsp_popped,
   output logic                                      rsp_was_empty,
   output logic                                      rsp_overflow,
   output logic        [sdsq_pkg::ENTRY_COUNT_W-1:0] rsp_entry_count
);
   import sdsq_pkg::*;

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int EXT_W = (CNT_W > ENTRY_COUNT_W) ? CNT_W : ENTRY_COUNT_W;

   logic [VALUE_W-1:0] entries_ff [QUEUE_DEPTH];
   logic [VALUE_W-1:0] entries_in [QUEUE_DEPTH];
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [VALUE_W-1:0] popped_ff, popped_in;
   logic               was_empty_ff, was_empty_in;
   logic               overflow_ff, overflow_in;
   logic [QUEUE_DEPTH-1:0] gt;
   logic               full, empty, do_push, do_pop;
   logic [EXT_W-1:0]   count_ext;

   assign full    = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = cmd.load && (req_cmd == CMD_PUSH) && !full;
   assign do_pop  = cmd.load && (req_cmd == CMD_POP) && !empty;

   genvar i;
   generate
      for (i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
         logic [VALUE_W-1:0] push_val, pop_val, shift_val;
         logic [VALUE_W:0]   diff;

         // valid entry strictly above the new value moves up one place
         assign gt[i] = (CNT_W'(i) < count_ff) && ($signed(entries_ff[i]) > req_value);

         if (i == 0) begin : g_head
            // an empty list takes the new value at the head
            assign push_val = (gt[0] || empty) ? req_value : entries_ff[0];
         end else begin : g_body
            always_comb begin
               if (gt[i-1]) begin
                  push_val = entries_ff[i-1];
               end else if (gt[i] || (CNT_W'(i) == count_ff)) begin
                  push_val = req_value;
               end else begin
                  push_val = entries_ff[i];
               end
            end
         end

         if (i < QUEUE_DEPTH - 1) begin : g_next
            assign diff = {entries_ff[i+1][VALUE_W-1], entries_ff[i+1]}
                        - {entries_ff[0][VALUE_W-1], entries_ff[0]};
            // saturate differences beyond the largest positive word
            assign pop_val   = (diff[VALUE_W] || diff[VALUE_W-1]) ? Q_MAX : diff[VALUE_W-1:0];
            assign shift_val = entries_ff[i+1];
         end else begin : g_last
            assign diff      = '0;
            assign pop_val   = entries_ff[i] | diff[VALUE_W-1:0];
            assign shift_val = entries_ff[i];
         end

         always_comb begin
            priority if (do_push) begin
               entries_in[i] = push_val;
            end else if (do_pop) begin
               entries_in[i] = pop_val;
            end else if (cmd.squeeze) begin
               entries_in[i] = shift_val;
            end else begin
               entries_in[i] = entries_ff[i];
            end
         end

         always_ff @(posedge clock) begin
            entries_ff[i] <= entries_in[i];
         end
      end
   endgenerate

   always_comb begin
      priority if (do_push) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop || cmd.squeeze) begin
         count_in = count_ff - CNT_W'(1);
      end else begin
         count_in = count_ff;
      end
   end

   always_comb begin
      popped_in    = popped_ff;
      was_empty_in = was_empty_ff;
      overflow_in  = overflow_ff;
      if (cmd.load) begin
         popped_in    = do_pop ? entries_ff[0] : '0;
         was_empty_in = (req_cmd == CMD_POP) && empty;
         overflow_in  = (req_cmd == CMD_PUSH) && full;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      popped_ff    <= popped_in;
      was_empty_ff <= was_empty_in;
      overflow_ff  <= overflow_in;
   end

   assign status.empty     = empty;
   assign status.head_zero = (entries_ff[0] == '0);

   assign count_ext       = EXT_W'(count_ff);
   assign rsp_popped      = popped_ff;
   assign rsp_was_empty   = was_empty_ff;
   assign rsp_overflow    = overflow_ff;
   assign rsp_entry_count = count_ext[ENTRY_COUNT_W-1:0];

endmodule

/* design/sorted_delta_shift_queue.sv */
// top level of the sorted delta shift queue
// instantiates sdsq_ctrl and sdsq_datapath; depends on sdsq_pkg
//
// latency: push and empty pop strobe rsp_valid in the cycle after the transaction;
//   a pop that finds entries strobes once ST_SQUEEZE has dropped every zeroed duplicate of the minimum
// busy: a new transaction is taken only in idle, once the controller's load, squeeze and
//   response steps of the last one are through
// reset: synchronous; empties the list, entry storage is not cleared
module sorted_delta_shift_queue #(
   parameter int QUEUE_DEPTH = sdsq_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      start,
   output logic                                      busy,
   input  logic                                      req_cmd,
   input  logic signed [sdsq_pkg::VALUE_W-1:0]       req_value,
   output logic                                      rsp_valid,
   output logic signed [sdsq_pkg::VALUE_W-1:0]       rsp_popped,
   output logic                                      rsp_was_empty,
   output logic                                      rsp_overflow,
   output logic        [sdsq_pkg::ENTRY_COUNT_W-1:0] rsp_entry_count
);
   import sdsq_pkg::*;

   // command and status between the sequencer and the entry cells
   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   // controller: idle, squeeze of zeroed duplicates, one-cycle response strobe
   sdsq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_cmd   (req_cmd),
      .status    (dp_status),
      .cmd       (dp_cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   // datapath: every cell compares and shifts, and all but the last subtract, in parallel
   sdsq_datapath #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (dp_cmd),
      .req_cmd         (req_cmd),
      .req_value       (req_value),
      .status          (dp_status),
      .rsp_popped      (rsp_popped),
      .rsp_was_empty   (rsp_was_empty),
      .rsp_overflow    (rsp_overflow),
      .rsp_entry_count (rsp_entry_count)
   );

endmodule

/* design/sdsq_checker.sv */
// port-level checker of the sorted delta shift queue and its bind to the top level
// depends on sdsq_pkg and sorted_delta_shift_queue_defines.svh
`include "sorted_delta_shift_queue_defines.svh"

module sdsq_checker (
   input logic                                      clock,
   input logic                                      reset,
   input logic                                      start,
   input logic                                      busy,
   input logic                                      rsp_valid,
   input logic signed [sdsq_pkg::VALUE_W-1:0]       rsp_popped,
   input logic                                      rsp_was_empty,
   input logic                                      rsp_overflow,
   input logic        [sdsq_pkg::ENTRY_COUNT_W-1:0] rsp_entry_count
);
   import sdsq_pkg::*;

   // a response only shows while a transaction is in flight
   `SDSQ_ASSERT_NOW(a_rsp_while_busy, clock, reset, rsp_valid, busy)
   // an accepted transaction makes the block busy
   `SDSQ_ASSERT_NEXT(a_busy_after_accept, clock, reset, start && !busy, busy)
   // one strobe per transaction
   `SDSQ_ASSERT_NEXT(a_single_strobe, clock, reset, rsp_valid, !rsp_valid)
   // an empty pop returns zero, leaves nothing held and is no overflow
   `SDSQ_ASSERT_NOW(a_empty_pop, clock, reset, rsp_valid && rsp_was_empty, (rsp_popped == '0) && (rsp_entry_count == '0) && !rsp_overflow)

endmodule

bind sorted_delta_shift_queue sdsq_checker u_sdsq_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_popped      (rsp_popped),
   .rsp_was_empty   (rsp_was_empty),
   .rsp_overflow    (rsp_overflow),
   .rsp_entry_count (rsp_entry_count)
);

/* dv/sorted_delta_shift_queue_tb.sv */
// self-checking testbench of the sorted delta shift queue: directed then random push/pop traffic
// a scoreboard class predicts every response; depends on sdsq_pkg and sorted_delta_shift_queue
module sorted_delta_shift_queue_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import sdsq_pkg::*;

   localparam int          DEPTH        = QUEUE_DEPTH_DEF;
   localparam int          RANDOM_ITEMS = 1625;
   localparam int          QUIET_TAIL   = 200;     // final transactions sent without random idling
   localparam int          DRAIN_CYCLES = 40;      // outlasts a pop that squeezes 15 duplicates
   localparam int          MAX_REPORTS  = 10;
   localparam int unsigned CYCLE_LIMIT  = 400000;  // bound for the watchdog

   typedef logic signed [VALUE_W-1:0] shift_t;

   // one response transaction
   typedef struct {
      shift_t                   popped;
      logic                     was_empty;
      logic                     overflow;
      logic [ENTRY_COUNT_W-1:0] entry_count;
   } shift_rsp_t;

   // keeps a private copy of the sorted list and the responses still owed by the block
   class shift_list_scoreboard;
      shift_t     sorted_shifts[$];
      shift_rsp_t owed_rsp[$];
      int         mismatches = 0;

      function void log_mismatch(string msg);
         mismatches++;
         if (mismatches <= MAX_REPORTS) begin
            $display("%s", msg);
         end
      endfunction

      // work out the response of an accepted request and update the list
      function void note_request(logic cmd, shift_t value);
         shift_rsp_t rsp;
         shift_t     head;
         shift_t     kept[$];
         logic [VALUE_W-1:0] delta;
         int         pos;
         rsp.popped    = '0;
         rsp.was_empty = 1'b0;
         rsp.overflow  = 1'b0;
         if (cmd == CMD_PUSH) begin
            if (sorted_shifts.size() >= DEPTH) begin
               rsp.overflow = 1'b1;
            end else begin
               // equal values go behind the ones already held
               pos = sorted_shifts.size();
               while (pos > 0 && value < sorted_shifts[pos-1]) begin
                  pos--;
               end
               sorted_shifts.insert(pos, value);
            end
         end else if (sorted_shifts.size() == 0) begin
            rsp.was_empty = 1'b1;
         end else begin
            head = sorted_shifts.pop_front();
            foreach (sorted_shifts[i]) begin
               // entry is never below head, so the wrapped difference is the true one
               delta = sorted_shifts[i] - head;
               if (delta > Q_MAX) begin
                  delta = Q_MAX;
               end
               if (delta != '0) begin
                  kept.push_back(delta);
               end
            end
            sorted_shifts = kept;
            rsp.popped    = head;
         end
         rsp.entry_count = ENTRY_COUNT_W'(sorted_shifts.size());
         owed_rsp.push_back(rsp);
      endfunction

      function void check_response(shift_rsp_t got);
         shift_rsp_t exp;
         if (owed_rsp.size() == 0) begin
            log_mismatch($sformatf("unexpected response: popped %h was_empty %b overflow %b count %0d",
                                   got.popped, got.was_empty, got.overflow, got.entry_count));
            return;
         end
         exp = owed_rsp.pop_front();
         if (got.popped !== exp.popped || got.was_empty !== exp.was_empty ||
             got.overflow !== exp.overflow || got.entry_count !== exp.entry_count) begin
            log_mismatch($sformatf({"response mismatch: expected popped %h was_empty %b ",
                                    "overflow %b count %0d, got popped %h was_empty %b ",
                                    "overflow %b count %0d"},
                                   exp.popped, exp.was_empty, exp.overflow, exp.entry_count,
                                   got.popped, got.was_empty, got.overflow, got.entry_count));
         end
      endfunction
   endclass

   // every input has a known value from time zero
   logic                     clock     = 1'b0;
   logic                     reset     = 1'b1;
   logic                     start     = 1'b0;
   logic                     req_cmd   = CMD_PUSH;
   shift_t                   req_value = '0;
   logic                     busy;
   logic                     rsp_valid;
   shift_t                   rsp_popped;
   logic                     rsp_was_empty;
   logic                     rsp_overflow;
   logic [ENTRY_COUNT_W-1:0] rsp_entry_count;
   int unsigned              cycle_count = 0;

   shift_list_scoreboard shift_sb = new();

   sorted_delta_shift_queue i_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_cmd         (req_cmd),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_popped      (rsp_popped),
      .rsp_was_empty   (rsp_was_empty),
      .rsp_overflow    (rsp_overflow),
      .rsp_entry_count (rsp_entry_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // the receiver cannot stall, so every strobe is a response transaction
   always @(posedge clock) begin : rsp_monitor
      shift_rsp_t got;
      if (!reset && rsp_valid) begin
         got.popped      = rsp_popped;
         got.was_empty   = rsp_was_empty;
         got.overflow    = rsp_overflow;
         got.entry_count = rsp_entry_count;
         shift_sb.check_response(got);
      end
   end

   // watchdog: a hung handshake ends the run as a failure
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("simulation failed");
      $finish;
   end

   // one request transaction; start stays high if the next one follows without a gap
   task automatic issue(input logic cmd, input shift_t value, input int idle_cycles);
      if (idle_cycles > 0) begin
         start <= 1'b0;
         repeat (idle_cycles) @(posedge clock);
      end
      start     <= 1'b1;
      req_cmd   <= cmd;
      req_value <= value;
      @(posedge clock);
      while (busy) begin
         @(posedge clock);
      end
      shift_sb.note_request(cmd, value);
   endtask

   // hold the sender off until every owed response has come back
   task automatic drain_responses();
      start <= 1'b0;
      @(posedge clock);
      while (shift_sb.owed_rsp.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // duplicates are common so pops exercise the head squeeze; full-range words cover every bit
   function automatic shift_t pick_shift();
      case ($urandom_range(0, 7))
         0, 1, 2: return shift_t'((int'($urandom_range(0, 6)) - 3) * 65536);
         3: begin
            case ($urandom_range(0, 4))
               0:       return Q_MAX;
               1:       return shift_t'({1'b1, {(VALUE_W-1){1'b0}}});
               2:       return '0;
               3:       return '1;
               default: return shift_t'(1);
            endcase
         end
         4:       return shift_t'(int'($urandom_range(0, 8)) - 4);  // tiny fractional steps
         default: return shift_t'($urandom);
      endcase
   endfunction

   // bursts of idling with quiet stretches, none at all in the tail of the run
   function automatic int pick_idle(int idx);
      if (idx >= RANDOM_ITEMS - QUIET_TAIL || (idx / 150) % 4 == 3) begin
         return 0;
      end
      if ($urandom_range(0, 3) == 0) begin
         return $urandom_range(1, 15);
      end
      return 0;
   endfunction

   initial begin : stimulus
      int push_pct;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // pop of an empty list
      issue(CMD_POP, '0, 0);
      // extremes with a duplicated minimum: the pop yields two differences of Q_MAX, one of them saturated
      issue(CMD_PUSH, Q_MAX, 0);
      issue(CMD_PUSH, shift_t'({1'b1, {(VALUE_W-1){1'b0}}}), 0);
      issue(CMD_PUSH, shift_t'({1'b1, {(VALUE_W-1){1'b0}}}), 0);
      issue(CMD_PUSH, '1, 0);
      issue(CMD_POP, '0, 0);
      // the two remaining entries are both Q_MAX, so this pop empties the list
      issue(CMD_POP, '0, 0);
      issue(CMD_POP, '0, 0);
      // fill to the brim with negatives, zeros and repeats, then push once more into a full list
      for (int k = 0; k < DEPTH; k++) begin
         issue(CMD_PUSH, (k % 4 == 0) ? shift_t'(0) : shift_t'((k - 8) * 32768), 0);
      end
      issue(CMD_PUSH, Q_MAX, 0);

      // random traffic in phases that lean towards filling or draining the list
      push_pct = 50;
      for (int idx = 0; idx < RANDOM_ITEMS; idx++) begin
         if (idx % 64 == 0) begin
            case ($urandom_range(0, 4))
               0:       push_pct = 20;
               1:       push_pct = 95;
               2:       push_pct = 75;
               default: push_pct = 50;
            endcase
         end
         if (idx % 400 == 399) begin
            drain_responses();
         end
         issue(($urandom_range(1, 100) <= push_pct) ? CMD_PUSH : CMD_POP, pick_shift(),
               pick_idle(idx));
      end
      start <= 1'b0;

      while (shift_sb.owed_rsp.size() != 0) begin
         @(posedge clock);
      end
      // catch any stray strobe after the last response
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (shift_sb.mismatches == 0 && shift_sb.owed_rsp.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
